### sv/nearest_fingerprint_sad_match_defines.svh
// Assertion macros for the checker file.
// Expects clk_i and rst_ni in the scope of use.
`ifndef NEAREST_FINGERPRINT_SAD_MATCH_DEFINES_SVH
`define NEAREST_FINGERPRINT_SAD_MATCH_DEFINES_SVH

// clocked assertion, off during reset
`define NFSM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// same, also checked during reset
`define NFSM_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

### sv/nfsm_pkg.sv
// Types and constants for the fingerprint SAD match block.
// No dependencies.
`default_nettype none
package nfsm_pkg;

  // widest SAD over the supported grid sizes (64*64*255)
  localparam int unsigned SumW = 20;

  typedef enum logic [1:0] {
    ST_ADDED    = 2'd0,
    ST_FULL     = 2'd1,
    ST_MATCH    = 2'd2,
    ST_NO_MATCH = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_ACC,
    S_SCAN,
    S_OUT
  } fsm_e;

  typedef struct packed {
    logic            found;
    logic [SumW-1:0] sad;
    logic [15:0]     tag;
  } cand_t;

endpackage
`default_nettype wire

### sv/nfsm_ram.sv
// Generic single-port RAM with registered read.
// No dependencies.
`default_nettype none
module nfsm_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 1024
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] addr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  output logic      [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;
endmodule
`default_nettype wire

### sv/nfsm_cell.sv
// One table entry: stored bytes, tag, SAD accumulator and a search stage.
// Depends on nfsm_pkg and nfsm_ram.
`default_nettype none
module nfsm_cell
  import nfsm_pkg::*;
#(
  parameter int unsigned NPIX    = 1024,
  parameter int unsigned FULL    = 261120,
  parameter int unsigned SAD_W   = 18
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    active_i,
  input  wire logic                    wr_en_i,
  input  wire logic                    rd_en_i,
  input  wire logic [$clog2(NPIX)-1:0] addr_i,
  input  wire logic [7:0]              wdata_i,
  input  wire logic [7:0]              gray_i,
  input  wire logic                    acc_en_i,
  input  wire logic                    clr_i,
  input  wire logic                    tag_we_i,
  input  wire logic [15:0]             tag_i,
  input  wire cand_t                   cand_i,
  output cand_t                        cand_o
);
  logic [7:0]       stored;
  logic [7:0]       diff;
  logic [SAD_W:0]   sum;
  logic [SAD_W-1:0] acc_q, acc_d;
  logic [15:0]      tag_q;
  cand_t            cand_q, cand_d;

  nfsm_ram #(.WIDTH(8), .DEPTH(NPIX)) u_ram (
    .clk_i   (clk_i),
    .we_i    (wr_en_i),
    .re_i    (rd_en_i),
    .addr_i  (addr_i),
    .wdata_i (wdata_i),
    .rdata_o (stored)
  );

  always_comb begin
    diff  = (gray_i > stored) ? (gray_i - stored) : (stored - gray_i);
    sum   = {1'b0, acc_q} + {{(SAD_W+1-8){1'b0}}, diff};
    acc_d = acc_q;
    if (clr_i) begin
      acc_d = '0;
    end else if (acc_en_i && active_i) begin
      acc_d = (sum > (SAD_W+1)'(FULL)) ? SAD_W'(FULL) : sum[SAD_W-1:0];
    end
    cand_d = cand_i;
    if (active_i && (SumW'(acc_q) < cand_i.sad)) begin
      cand_d.found = 1'b1;
      cand_d.sad   = SumW'(acc_q);
      cand_d.tag   = tag_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q  <= '0;
      cand_q <= '0;
    end else begin
      acc_q  <= acc_d;
      cand_q <= cand_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (tag_we_i) begin
      tag_q <= tag_i;
    end
  end

  assign cand_o = cand_q;
endmodule
`default_nettype wire

### sv/nearest_fingerprint_sad_match.sv
// Add byte: taken in S_IDLE; the result of a last add byte is shown in the next cycle.
// Query byte: RAM read, then accumulate; a last query byte then scans
// the cell chain, one cell stage per cycle.
// One item in flight; next item taken after the result transfer.
// rst_ni asynchronous: count, position and accumulators cleared, bytes/tags kept.
`default_nettype none
module nearest_fingerprint_sad_match
  import nfsm_pkg::*;
#(
  parameter int unsigned FP_SIDE     = 32,
  parameter int unsigned MAX_ENTRIES = 64
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic        req_type_i,
  input  wire logic [7:0]  gray_byte_i,
  input  wire logic        is_last_i,
  input  wire logic [15:0] region_tag_i,
  input  wire logic [17:0] sad_limit_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [1:0]       status_o,
  output logic [15:0]      match_tag_o,
  output logic [17:0]      best_sad_o,
  output logic [6:0]       entry_count_o
);
  localparam int unsigned NPIX  = FP_SIDE * FP_SIDE;
  localparam int unsigned FULL  = NPIX * 255;
  localparam int unsigned SAD_W = $clog2(FULL + 1);
  localparam int unsigned POS_W = $clog2(NPIX);
  localparam int unsigned CNT_W = $clog2(MAX_ENTRIES + 1);

  fsm_e             state_q, state_d;
  logic [POS_W-1:0] pos_q, pos_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic [CNT_W-1:0] scan_q, scan_d;
  logic [7:0]       gray_q;
  logic             last_q;
  logic [SumW-1:0]  limit_q;
  status_e          status_q, status_d;
  logic [15:0]      mtag_q, mtag_d;
  logic [17:0]      best_q, best_d;
  logic             accept, add_ok, rd_en, acc_en, clr, tag_we;
  cand_t            chain [MAX_ENTRIES+1];

  assign accept = in_valid_i && in_ready_o;
  assign add_ok = count_q < CNT_W'(MAX_ENTRIES);

  always_comb begin
    state_d  = state_q;
    pos_d    = pos_q;
    count_d  = count_q;
    scan_d   = scan_q;
    status_d = status_q;
    mtag_d   = mtag_q;
    best_d   = best_q;
    rd_en    = 1'b0;
    acc_en   = 1'b0;
    clr      = 1'b0;
    tag_we   = 1'b0;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          pos_d = (32'(pos_q) + 1 >= NPIX) ? '0 : pos_q + 1'b1;
          if (is_last_i) begin
            pos_d = '0;
          end
          if (req_type_i) begin
            rd_en   = 1'b1;
            state_d = S_ACC;
          end else if (is_last_i) begin
            clr    = 1'b1;
            mtag_d = '0;
            best_d = '0;
            if (add_ok) begin
              tag_we   = 1'b1;
              count_d  = count_q + 1'b1;
              status_d = ST_ADDED;
            end else begin
              status_d = ST_FULL;
            end
            state_d = S_OUT;
          end
        end
      end
      S_ACC: begin
        acc_en  = 1'b1;
        scan_d  = '0;
        state_d = last_q ? S_SCAN : S_IDLE;
      end
      S_SCAN: begin
        scan_d = scan_q + 1'b1;
        if (scan_q == CNT_W'(MAX_ENTRIES)) begin
          clr      = 1'b1;
          status_d = chain[MAX_ENTRIES].found ? ST_MATCH : ST_NO_MATCH;
          mtag_d   = chain[MAX_ENTRIES].tag;
          best_d   = chain[MAX_ENTRIES].sad[17:0];
          state_d  = S_OUT;
        end
      end
      S_OUT: begin
        out_valid_o = 1'b1;
        if (out_ready_i) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      pos_q   <= '0;
      count_q <= '0;
      scan_q  <= '0;
    end else begin
      state_q <= state_d;
      pos_q   <= pos_d;
      count_q <= count_d;
      scan_q  <= scan_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      gray_q  <= gray_byte_i;
      last_q  <= is_last_i;
      limit_q <= (SumW'(sad_limit_i) > SumW'(FULL)) ? SumW'(FULL) : SumW'(sad_limit_i);
    end
    status_q <= status_d;
    mtag_q   <= mtag_d;
    best_q   <= best_d;
  end

  assign chain[0] = {1'b0, limit_q, 16'h0000};

  for (genvar k = 0; k < MAX_ENTRIES; k++) begin : g_cell
    nfsm_cell #(.NPIX(NPIX), .FULL(FULL), .SAD_W(SAD_W)) u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .active_i (CNT_W'(k) < count_q),
      .wr_en_i  (accept && !req_type_i && (count_q == CNT_W'(k))),
      .rd_en_i  (rd_en),
      .addr_i   (pos_q),
      .wdata_i  (gray_byte_i),
      .gray_i   (gray_q),
      .acc_en_i (acc_en),
      .clr_i    (clr),
      .tag_we_i (tag_we && (count_q == CNT_W'(k))),
      .tag_i    (region_tag_i),
      .cand_i   (chain[k]),
      .cand_o   (chain[k+1])
    );
  end

  assign status_o      = status_q;
  assign match_tag_o   = mtag_q;
  assign best_sad_o    = best_q;
  assign entry_count_o = 7'(count_q);
endmodule
`default_nettype wire

### sv/nfsm_checker.sv
// Port-level checks for the fingerprint SAD match block, bound to the top.
// Depends on nfsm_pkg and nearest_fingerprint_sad_match_defines.svh.
`default_nettype none
`include "nearest_fingerprint_sad_match_defines.svh"
module nfsm_checker
  import nfsm_pkg::*;
#(
  parameter int unsigned MAX_ENTRIES = 64
) (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        in_ready_o,
  input wire logic        out_valid_o,
  input wire logic        out_ready_i,
  input wire logic [1:0]  status_o,
  input wire logic [15:0] match_tag_o,
  input wire logic [17:0] best_sad_o,
  input wire logic [6:0]  entry_count_o
);
  `NFSM_ASSERT(a_out_hold, out_valid_o && !out_ready_i |=> out_valid_o && $stable(status_o), "result dropped before transfer")
  `NFSM_ASSERT(a_no_overlap, out_valid_o |-> !in_ready_o, "input taken while result pending")
  `NFSM_ASSERT(a_count_max, 32'(entry_count_o) <= MAX_ENTRIES, "entry count above table size")
  `NFSM_ASSERT(a_add_zero, out_valid_o && (status_o == ST_ADDED || status_o == ST_FULL) |-> match_tag_o == 16'd0 && best_sad_o == 18'd0, "add result carries match data")
  `NFSM_ASSERT_ALWAYS(a_reset_idle, !rst_ni |-> !out_valid_o, "result valid in reset")
endmodule

bind nearest_fingerprint_sad_match nfsm_checker #(.MAX_ENTRIES(MAX_ENTRIES)) u_nfsm_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_ready_o    (in_ready_o),
  .out_valid_o   (out_valid_o),
  .out_ready_i   (out_ready_i),
  .status_o      (status_o),
  .match_tag_o   (match_tag_o),
  .best_sad_o    (best_sad_o),
  .entry_count_o (entry_count_o)
);
`default_nettype wire

### tb/sv/tb_nearest_fingerprint_sad_match.sv
`timescale 1ns / 100ps
// Self-checking testbench for nearest_fingerprint_sad_match: a local predictor
// follows every accepted byte and each result transfer is compared field by field.
// Depends on nfsm_pkg and the block RTL only.
module tb_nearest_fingerprint_sad_match;
  import nfsm_pkg::*;

  localparam int unsigned Side    = 32;
  localparam int unsigned Entries = 64;
  localparam int unsigned NPix    = Side * Side;
  localparam int unsigned FullSad = NPix * 255;
  localparam logic        ReqAdd  = 1'b0;
  localparam logic        ReqQry  = 1'b1;

  typedef struct packed {
    status_e     status;
    logic [15:0] tag;
    logic [17:0] sad;
    logic [6:0]  count;
  } answer_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic        req_type_i = 1'b0;
  logic [7:0]  gray_byte_i = '0;
  logic        is_last_i = 1'b0;
  logic [15:0] region_tag_i = '0;
  logic [17:0] sad_limit_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [1:0]  status_o;
  logic [15:0] match_tag_o;
  logic [17:0] best_sad_o;
  logic [6:0]  entry_count_o;

  nearest_fingerprint_sad_match #(.FP_SIDE(Side), .MAX_ENTRIES(Entries)) dut (.*);

  always #5 clk_i = ~clk_i;

  // predictor state
  logic [7:0]  fp_mem [Entries][NPix];
  bit          fp_written [Entries][NPix];
  logic [15:0] fp_tags [Entries];
  int unsigned fp_count;
  int unsigned sad_acc [Entries];
  int unsigned byte_pos;

  answer_t     answers_q[$];
  int          errors = 0;
  int          sent = 0;
  bit          idle_en = 1'b1;
  int          hold_req = 0;

  task automatic predict_byte(logic t, logic [7:0] g, logic last, logic [15:0] tag,
                              logic [17:0] lim);
    int unsigned p, s, d, a, best;
    answer_t r;
    p = byte_pos;
    if (t == ReqQry) begin
      for (int e = 0; e < fp_count; e++) begin
        s = fp_mem[e][p];
        d = (g > s) ? g - s : s - g;
        a = sad_acc[e] + d;
        sad_acc[e] = (a > FullSad) ? FullSad : a;
      end
    end else if (fp_count < Entries) begin
      fp_mem[fp_count][p] = g;
      fp_written[fp_count][p] = 1'b1;
    end
    byte_pos = (p + 1 >= NPix) ? 0 : p + 1;
    if (last) begin
      r = '0;
      if (t == ReqQry) begin
        best = (lim > FullSad) ? FullSad : lim;
        r.status = ST_NO_MATCH;
        for (int e = 0; e < fp_count; e++) begin
          if (sad_acc[e] < best) begin
            best = sad_acc[e];
            r.tag = fp_tags[e];
            r.status = ST_MATCH;
          end
        end
        r.sad = 18'(best);
      end else if (fp_count < Entries) begin
        fp_tags[fp_count] = tag;
        fp_count++;
        r.status = ST_ADDED;
      end else begin
        r.status = ST_FULL;
      end
      r.count = 7'(fp_count);
      answers_q.push_back(r);
      foreach (sad_acc[e]) sad_acc[e] = 0;
      byte_pos = 0;
    end
  endtask

  // a query byte must not read a stored byte that was never written
  function automatic bit query_ok();
    for (int e = 0; e < fp_count; e++)
      if (!fp_written[e][byte_pos]) return 1'b0;
    return 1'b1;
  endfunction

  task automatic send_byte(logic t, logic [7:0] g, logic last, logic [15:0] tag,
                           logic [17:0] lim);
    if (t == ReqQry && !query_ok()) t = ReqAdd;
    if (idle_en && $urandom_range(0, 5) == 0) begin
      in_valid_i = 1'b0;
      repeat ($urandom_range(1, 19)) @(negedge clk_i);
    end
    in_valid_i   = 1'b1;
    req_type_i   = t;
    gray_byte_i  = g;
    is_last_i    = last;
    region_tag_i = tag;
    sad_limit_i  = lim;
    forever begin
      @(posedge clk_i);
      if (in_ready_o) break;
    end
    predict_byte(t, g, last, tag, lim);
    sent++;
    @(negedge clk_i);
    in_valid_i = 1'b0;
  endtask

  task automatic send_stream(logic t, int len, logic [15:0] tag, logic [17:0] lim);
    for (int i = 0; i < len; i++)
      send_byte(t, 8'($urandom_range(0, 255)), i == len - 1, tag, lim);
  endtask

  // receiver: random stall bursts, plus a long hold-off on request
  initial begin
    int stall;
    stall = 0;
    forever begin
      @(negedge clk_i);
      if (!rst_ni) begin
        out_ready_i = 1'b0;
      end else if (hold_req > 0) begin
        out_ready_i = 1'b0;
        hold_req--;
      end else if (stall > 0) begin
        out_ready_i = 1'b0;
        stall--;
      end else if (idle_en && $urandom_range(0, 7) == 0) begin
        out_ready_i = 1'b0;
        stall = $urandom_range(1, 19) - 1;
      end else begin
        out_ready_i = 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    answer_t x;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (answers_q.size() == 0) begin
        $display("%0t: unexpected result transfer status=%0d", $time, status_o);
        errors++;
      end else begin
        x = answers_q.pop_front();
        if (status_o !== x.status) begin
          $display("%0t: status expected %0d actual %0d", $time, x.status, status_o);
          errors++;
        end
        if (match_tag_o !== x.tag) begin
          $display("%0t: match_tag expected %h actual %h", $time, x.tag, match_tag_o);
          errors++;
        end
        if (best_sad_o !== x.sad) begin
          $display("%0t: best_sad expected %0d actual %0d", $time, x.sad, best_sad_o);
          errors++;
        end
        if (entry_count_o !== x.count) begin
          $display("%0t: entry_count expected %0d actual %0d", $time, x.count,
                   entry_count_o);
          errors++;
        end
      end
    end
  end

  task automatic test_empty_table();
    send_byte(ReqQry, 8'h00, 1'b1, 16'h0000, 18'd0);
    send_byte(ReqQry, 8'hFF, 1'b1, 16'hFFFF, 18'd261120);
  endtask

  // slot 0 holds a complete fingerprint so long queries stay legal
  task automatic test_full_entry();
    for (int i = 0; i < NPix; i++)
      send_byte(ReqAdd, (i == NPix - 1) ? 8'hFF : 8'h00, i == NPix - 1, 16'hFFFF, '0);
  endtask

  task automatic test_extremes();
    send_byte(ReqQry, 8'hFF, 1'b1, 16'h0000, 18'd261120);
    send_byte(ReqQry, 8'h00, 1'b1, 16'h0000, 18'd0);
    send_byte(ReqQry, 8'h00, 1'b1, 16'h0000, 18'd1);
    for (int i = 0; i < 16; i++) send_byte(ReqAdd, 8'hFF, i == 15, 16'h0000, 18'd0);
    for (int i = 0; i < 16; i++) send_byte(ReqAdd, 8'h00, i == 15, 16'hA5A5, 18'd0);
    send_byte(ReqQry, 8'h00, 1'b0, 16'h0000, 18'd0);
    send_byte(ReqQry, 8'h00, 1'b1, 16'h0000, 18'd261120);
  endtask

  // query longer than a frame: position wraps and sums saturate
  task automatic test_wrap_saturate();
    fork
      begin
        for (int i = 0; i < NPix + 80; i++)
          send_byte(ReqQry, 8'hFF, i == NPix + 79, 16'h0000, 18'd261120);
      end
    join
  endtask

  task automatic test_backpressure();
    hold_req = 300;
    for (int i = 0; i < 4; i++)
      send_byte(ReqQry, 8'($urandom_range(0, 255)), 1'b1, '0, 18'd500);
  endtask

  task automatic test_random(int n_items);
    int kind, len;
    logic [17:0] lim;
    while (sent < n_items) begin
      if (sent > n_items - 200) idle_en = 1'b0;
      kind = $urandom_range(0, 9);
      lim = ($urandom_range(0, 3) == 0) ? 18'($urandom_range(0, 261120))
                                        : 18'($urandom_range(0, 2500));
      if (kind < 4) begin
        send_stream(ReqAdd, (fp_count < Entries) ? $urandom_range(16, 24)
                                                 : $urandom_range(1, 20),
                    16'($urandom_range(0, 65535)), lim);
      end else if (kind < 8) begin
        send_stream(ReqQry, $urandom_range(1, 16), '0, lim);
      end else begin
        len = $urandom_range(1, 30);
        for (int i = 0; i < len; i++)
          send_byte(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)), i == len - 1,
                    16'($urandom_range(0, 65535)), lim);
      end
    end
  endtask

  initial begin
    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    test_empty_table();
    test_full_entry();
    test_wrap_saturate();
    test_extremes();
    test_backpressure();
    sent = 0;
    test_random(1450);
    wait (answers_q.size() == 0);
    repeat (200) @(posedge clk_i);
    if (errors == 0 && answers_q.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("Some tests failed");
    $finish;
  end

endmodule

### files.f
+incdir+sv
sv/nfsm_pkg.sv
sv/nfsm_ram.sv
sv/nfsm_cell.sv
sv/nearest_fingerprint_sad_match.sv
sv/nfsm_checker.sv
tb/sv/tb_nearest_fingerprint_sad_match.sv
